>>> hw/rtl/b64e_pkg.sv
`default_nettype none
package b64e_pkg;

	localparam int LINE_LENGTH = 76;
	localparam int COL_W       = $clog2(LINE_LENGTH);
	localparam int MAX_CHARS   = 5;
	localparam int CNT_W       = $clog2(MAX_CHARS + 1);
	localparam int FIFO_DEPTH  = 4;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_UPPER = 8'h41;
	localparam logic [7:0] CH_LOWER = 8'h61;
	localparam logic [7:0] CH_DIGIT = 8'h30;

	localparam logic REG_NEWLINES = 1'b0;
	localparam logic REG_PAD      = 1'b1;

	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [CNT_W-1:0]          cnt;
		logic                      last;
	} b64e_entry_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = CH_UPPER + {2'b00, v};
		end else if (v < 6'd52) begin
			r = CH_LOWER + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			r = CH_DIGIT + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			r = CH_PLUS;
		end else begin
			r = CH_SLASH;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/base64_stream_encoder.sv
// Channel | Signals                                       | Dir
// --------+-----------------------------------------------+-----
// input   | in_valid, in_ready, data_byte, last_byte       | in
// output  | out_valid, out_ready, out_char, run_last,      | out
//         | message_end                                   |
// config  | cfg_we, cfg_index, cfg_wdata                  | in
//
// One byte beat per cycle is taken while the four-entry queue has room.
// The back end emits one character per cycle unless out_ready stalls it or the queue
// is empty, 1 to 5 per byte, so long messages are paced by the back end; with the
// queue empty the first character goes through a queue entry, then the output register.
// Reset clears the group state, line column and queue; both options reset to 1.
// Output stalls back up into the queue, then into in_ready.
`default_nettype none
module base64_stream_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic       cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_char,
	output logic            run_last,
	output logic            message_end
);
	import b64e_pkg::*;

	b64e_entry_t q_data;
	b64e_entry_t q_head;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;

	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	b64e_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (q_head)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule
`default_nettype wire

>>> hw/rtl/b64e_front.sv
`default_nettype none
module b64e_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic                 cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 last_byte,
	input  wire logic                 q_full,
	output logic                      q_push,
	output b64e_pkg::b64e_entry_t     q_data
);
	import b64e_pkg::*;

	logic             newlines_q;
	logic             pad_q;
	logic [3:0]       lo_q;
	logic [1:0]       phase_q;
	logic [COL_W-1:0] col_q;

	logic [5:0]       s0, s1;
	logic             two;
	logic [3:0]       lo_n;
	logic [1:0]       phase_n;
	logic [1:0]       pads;
	logic [COL_W:0]   c1, c2;
	logic             w0, w1;
	logic [COL_W-1:0] col_a, col_b, col_n;
	logic [CNT_W-1:0] pos;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	always_comb begin
		s1      = '0;
		two     = 1'b0;
		pads    = 2'd0;
		case (phase_q)
			2'd1: begin
				s0      = {lo_q[1:0], data_byte[7:4]};
				lo_n    = data_byte[3:0];
				phase_n = 2'd2;
				if (last_byte) begin
					s1   = {lo_n, 2'b00};
					two  = 1'b1;
					pads = 2'd1;
				end
			end
			2'd2: begin
				s0      = {lo_q, data_byte[7:6]};
				s1      = data_byte[5:0];
				two     = 1'b1;
				lo_n    = 4'd0;
				phase_n = 2'd0;
			end
			default: begin
				s0      = data_byte[7:2];
				lo_n    = {2'b00, data_byte[1:0]};
				phase_n = 2'd1;
				if (last_byte) begin
					s1   = {lo_n[1:0], 4'b0000};
					two  = 1'b1;
					pads = 2'd2;
				end
			end
		endcase

		c1    = {1'b0, col_q} + (COL_W+1)'(1);
		w0    = c1 >= (COL_W+1)'(LINE_LENGTH);
		col_a = w0 ? '0 : c1[COL_W-1:0];
		c2    = {1'b0, col_a} + (COL_W+1)'(1);
		w1    = two && (c2 >= (COL_W+1)'(LINE_LENGTH));
		col_b = w1 ? '0 : c2[COL_W-1:0];
		col_n = two ? col_b : col_a;

		q_data      = '0;
		q_data.last = last_byte;
		pos         = '0;
		q_data.chars[pos] = sextet_char(s0);
		pos = pos + CNT_W'(1);
		if (w0 && newlines_q) begin
			q_data.chars[pos] = CH_LF;
			pos = pos + CNT_W'(1);
		end
		if (two) begin
			q_data.chars[pos] = sextet_char(s1);
			pos = pos + CNT_W'(1);
		end
		if (w1 && newlines_q) begin
			q_data.chars[pos] = CH_LF;
			pos = pos + CNT_W'(1);
		end
		if (pad_q && pads != 2'd0) begin
			q_data.chars[pos] = CH_EQ;
			pos = pos + CNT_W'(1);
		end
		if (pad_q && pads == 2'd2) begin
			q_data.chars[pos] = CH_EQ;
			pos = pos + CNT_W'(1);
		end
		q_data.cnt = pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newlines_q <= 1'b1;
			pad_q      <= 1'b1;
			lo_q       <= '0;
			phase_q    <= '0;
			col_q      <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_NEWLINES) begin
				newlines_q <= cfg_wdata;
			end
			if (cfg_we && cfg_index == REG_PAD) begin
				pad_q <= cfg_wdata;
			end
			if (q_push) begin
				if (last_byte) begin
					lo_q    <= '0;
					phase_q <= '0;
					col_q   <= '0;
				end else begin
					lo_q    <= lo_n;
					phase_q <= phase_n;
					col_q   <= col_n;
				end
			end
		end
	end

	a_phase_valid: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("group phase reached unused code");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < (COL_W+1)'(LINE_LENGTH))
		else $error("line column out of range");

endmodule
`default_nettype wire

>>> hw/rtl/b64e_fifo.sv
`default_nettype none
module b64e_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire b64e_pkg::b64e_entry_t push_data,
	input  wire logic                  pop,
	output logic                       full,
	output logic                       empty,
	output b64e_pkg::b64e_entry_t      head
);
	import b64e_pkg::*;

	b64e_entry_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [FCNT_W-1:0] cnt_q;

	assign full  = cnt_q == FCNT_W'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underflow");

endmodule
`default_nettype wire

>>> hw/rtl/b64e_back.sv
`default_nettype none
module b64e_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	input  wire b64e_pkg::b64e_entry_t q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_char,
	output logic                       run_last,
	output logic                       message_end
);
	import b64e_pkg::*;

	logic [CNT_W-1:0] idx_q;
	logic             valid_q;
	logic [7:0]       char_q;
	logic             run_last_q;
	logic             msg_end_q;
	logic             adv;
	logic             at_end;

	assign adv    = (!valid_q || out_ready) && !q_empty;
	assign at_end = idx_q == (q_head.cnt - CNT_W'(1));
	assign q_pop  = adv && at_end;

	assign out_valid   = valid_q;
	assign out_char    = char_q;
	assign run_last    = run_last_q;
	assign message_end = msg_end_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q     <= q_head.chars[idx_q];
			run_last_q <= at_end;
			msg_end_q  <= at_end && q_head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (adv) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? '0 : idx_q + CNT_W'(1);
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && msg_end_q) |-> run_last_q)
		else $error("message end without run end");

	a_idx_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q < q_head.cnt))
		else $error("character index past entry");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import b64e_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} msg_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       msg_end;
	} encoded_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = REG_NEWLINES;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       run_last;
	logic       message_end;

	base64_stream_encoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.run_last    (run_last),
		.message_end (message_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("base64_stream_encoder: mismatch");
		$finish;
	end

	// encoder model state
	string      b64_alphabet =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	logic       cfg_newlines = 1'b1;
	logic       cfg_pad = 1'b1;
	logic [3:0] carry_bits = '0;
	logic [1:0] grp_phase = '0;
	logic [6:0] line_col = '0;

	logic [7:0]    step_chars[$];
	encoded_char_t expected_chars[$];
	msg_byte_t     pending_bytes[$];

	int n_mismatch = 0;
	int n_bytes = 0;
	int n_msgs = 0;
	int n_chars = 0;
	int n_lf = 0;
	int n_pad = 0;

	task automatic push_symbol(input logic [5:0] v);
		step_chars.insert(step_chars.size(), b64_alphabet[v]);
		line_col = line_col + 7'd1;
		if (line_col >= LINE_LENGTH) begin
			line_col = '0;
			if (cfg_newlines)
				step_chars.insert(step_chars.size(), CH_LF);
		end
	endtask

	task automatic encode_byte(input logic [7:0] b, input logic fin);
		int            pads;
		encoded_char_t e;
		pads = 0;
		step_chars.delete();
		case (grp_phase)
			2'd1: begin
				push_symbol({carry_bits[1:0], b[7:4]});
				carry_bits = b[3:0];
				grp_phase = 2'd2;
			end
			2'd2: begin
				push_symbol({carry_bits, b[7:6]});
				push_symbol(b[5:0]);
				carry_bits = '0;
				grp_phase = 2'd0;
			end
			default: begin
				push_symbol(b[7:2]);
				carry_bits = {2'b00, b[1:0]};
				grp_phase = 2'd1;
			end
		endcase
		if (fin) begin
			if (grp_phase == 2'd1) begin
				push_symbol({carry_bits[1:0], 4'b0000});
				pads = 2;
			end else if (grp_phase == 2'd2) begin
				push_symbol({carry_bits, 2'b00});
				pads = 1;
			end
			if (cfg_pad)
				repeat (pads) step_chars.insert(step_chars.size(), CH_EQ);
			carry_bits = '0;
			grp_phase = '0;
			line_col = '0;
		end
		foreach (step_chars[i]) begin
			e.ch = step_chars[i];
			e.run_last = (i == step_chars.size() - 1);
			e.msg_end = fin && e.run_last;
			expected_chars.insert(expected_chars.size(), e);
		end
	endtask

	// input driver: bursts with random gaps
	logic      in_taken = 1'b0;
	int        burst_left = 1;
	int        gap_left = 0;
	msg_byte_t next_byte;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (gap_left != 0 || pending_bytes.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				next_byte = pending_bytes.pop_front();
				data_byte <= next_byte.data;
				last_byte <= next_byte.last;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// output stall pattern
	int rx_mode = 0;
	int rx_left = 0;
	int rx_tick = 0;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(32, 200);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 4) == 0);
			default: out_ready <= ((rx_tick % 11) < 3);
		endcase
	end

	// monitor and checker
	encoded_char_t want;

	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			encode_byte(data_byte, last_byte);
			n_bytes++;
			if (last_byte)
				n_msgs++;
		end
		if (arst_n && out_valid && out_ready) begin
			n_chars++;
			if (out_char == CH_LF)
				n_lf++;
			if (out_char == CH_EQ)
				n_pad++;
			if (expected_chars.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected beat: char=%02h run_last=%b message_end=%b",
						out_char, run_last, message_end);
			end else begin
				want = expected_chars.pop_front();
				if (out_char !== want.ch || run_last !== want.run_last ||
						message_end !== want.msg_end) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("beat %0d: exp char=%02h rl=%b me=%b, got char=%02h rl=%b me=%b",
							n_chars, want.ch, want.run_last, want.msg_end,
							out_char, run_last, message_end);
				end
			end
		end
	end

	task automatic queue_message(input logic [7:0] bytes[$]);
		msg_byte_t m;
		foreach (bytes[i]) begin
			m.data = bytes[i];
			m.last = (i == bytes.size() - 1);
			pending_bytes.insert(pending_bytes.size(), m);
		end
	endtask

	task automatic queue_random_messages(input int target);
		int         count;
		int         len;
		int         sel;
		logic [7:0] bytes[$];
		count = 0;
		while (count < target) begin
			sel = $urandom_range(0, 9);
			if (sel <= 5)
				len = $urandom_range(1, 6);
			else if (sel <= 7)
				len = $urandom_range(7, 20);
			else if (sel == 8)
				len = $urandom_range(50, 130);
			else
				len = 57 * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
			if (len > target - count)
				len = target - count;
			bytes.delete();
			repeat (len) begin
				case ($urandom_range(0, 7))
					0: bytes.insert(bytes.size(), 8'h00);
					1: bytes.insert(bytes.size(), 8'hFF);
					default: bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
				endcase
			end
			queue_message(bytes);
			count += len;
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NEWLINES)
			cfg_newlines = val;
		else
			cfg_pad = val;
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		queue_message('{8'h00});
		queue_message('{8'hFF});
		queue_message('{8'hFF, 8'hFF});
		queue_message('{8'hFB, 8'hEF, 8'hBE});
		queue_message('{8'hFF, 8'hFF, 8'hFF});
		queue_message('{8'h00, 8'h00, 8'h00});
		queue_message('{8'h4D, 8'h61, 8'h6E, 8'h80});
		queue_message('{8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55});
		wait_drained();

		write_reg(REG_NEWLINES, 1'b0);
		queue_random_messages(90);
		wait_drained();

		write_reg(REG_NEWLINES, 1'b1);
		write_reg(REG_PAD, 1'b0);
		queue_random_messages(90);
		wait_drained();

		write_reg(REG_NEWLINES, 1'b0);
		queue_random_messages(90);
		wait_drained();

		write_reg(REG_NEWLINES, 1'b1);
		write_reg(REG_PAD, 1'b1);
		queue_random_messages(90);
		wait_drained();
		repeat (20) @(posedge clk);

		if (expected_chars.size() != 0) begin
			n_mismatch += expected_chars.size();
			$display("%0d expected characters never arrived", expected_chars.size());
		end
		$display("encoded %0d bytes in %0d messages over four option settings",
			n_bytes, n_msgs);
		$display("checked %0d characters: %0d line feeds, %0d pad, %0d errors",
			n_chars, n_lf, n_pad, n_mismatch);
		if (n_mismatch == 0)
			$display("base64_stream_encoder: match");
		else
			$display("base64_stream_encoder: mismatch");
		$finish;
	end

endmodule
